[hdl/aging_neighbor_table_macros.svh]
// Assertion macros shared by the neighbor table RTL.
// Expects signals named clock and reset in the scope of each use.
`ifndef AGING_NEIGHBOR_TABLE_MACROS_SVH
`define AGING_NEIGHBOR_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define ANT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ANT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/ant_pkg.sv]
// Package for the aging neighbor table: widths, codes, record layout and
// controller/datapath command and status structs. No dependencies.
package ant_pkg;

   localparam int unsigned ANT_TABLE_ENTRIES = 16;

   localparam int unsigned CMD_W    = 2;
   localparam int unsigned ADDR_W   = 48;
   localparam int unsigned RSSI_W   = 8;
   localparam int unsigned BATT_W   = 16;
   localparam int unsigned TEMP_W   = 16;
   localparam int unsigned AGE_W    = 16;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned SLOT_W   = 4;

   localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd60;

   localparam logic [CMD_W-1:0] CMD_REPORT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TICK    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TAKEN   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NONE    = 3'd5;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [AGE_W-1:0]  age;
      logic              sent;
      logic [RSSI_W-1:0] rssi;
      logic [BATT_W-1:0] batt;
      logic [TEMP_W-1:0] temp;
   } ant_rec_type;

   // controller -> datapath
   typedef struct packed {
      logic start;     // capture request, restart scan
      logic scan;      // walk the table
      logic finish;    // close out a scan without a hit
      logic rsp_load;  // move result into the output register
   } ant_ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_end;  // last slot is being evaluated
      logic hit;       // current slot ends the item early
      logic rsp_full;  // output register holds an untaken item
   } ant_stat_type;

endpackage

[hdl/ant_req_if.sv]
// Request channel of the neighbor table: valid/ready plus parsed fields.
// Depends on ant_pkg.
interface ant_req_if;
   import ant_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ADDR_W-1:0] node_address;
   logic [RSSI_W-1:0] signal_strength;
   logic [BATT_W-1:0] battery_level;
   logic [TEMP_W-1:0] temperature_word;

   modport source (output valid, command, node_address, signal_strength,
                   battery_level, temperature_word, input ready);
   modport sink   (input valid, command, node_address, signal_strength,
                   battery_level, temperature_word, output ready);
endinterface

[hdl/ant_rsp_if.sv]
// Response channel of the neighbor table: valid/ready plus result fields.
// Depends on ant_pkg.
interface ant_rsp_if;
   import ant_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_index;
   logic [ADDR_W-1:0]   out_address;
   logic [RSSI_W-1:0]   out_strength;
   logic [BATT_W-1:0]   out_battery;
   logic [TEMP_W-1:0]   out_temperature;

   modport source (output valid, status, slot_index, out_address, out_strength,
                   out_battery, out_temperature, input ready);
   modport sink   (input valid, status, slot_index, out_address, out_strength,
                   out_battery, out_temperature, output ready);
endinterface

[hdl/ant_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ant_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[hdl/ant_ctrl.sv]
// Controller of the neighbor table: sequences accept, scan, finish and
// output load. Depends on ant_pkg and the assertion macro header.
`include "aging_neighbor_table_macros.svh"

module ant_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   input  ant_pkg::ant_stat_type stat,
   output ant_pkg::ant_ctl_type  ctl
);
   import ant_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_FINISH = 4'b0100,
      S_OUTPUT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               ctl.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            ctl.scan = 1'b1;
            if (stat.hit) begin
               state_in = S_OUTPUT;
            end else if (stat.scan_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            ctl.finish = 1'b1;
            state_in   = S_OUTPUT;
         end
         S_OUTPUT: begin
            if (!stat.rsp_full || rsp_ready) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ANT_ASSERT_NOW(a_load_free, ctl.rsp_load, !stat.rsp_full || rsp_ready, "output overwritten")
   `ANT_ASSERT_NEXT(a_scan_stops, stat.scan_end, state_ff != S_SCAN, "scan ran past the table")
endmodule

[hdl/ant_dpath.sv]
// Datapath of the neighbor table: request capture, valid bits, record RAM,
// scan pipeline, result and output registers. Depends on ant_pkg, ant_ram.
`include "aging_neighbor_table_macros.svh"

module ant_dpath #(
   parameter int unsigned TABLE_ENTRIES = ant_pkg::ANT_TABLE_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ant_pkg::ant_ctl_type            ctl,
   output ant_pkg::ant_stat_type           stat,
   input  logic                            csr_we,
   input  logic [ant_pkg::AGE_W-1:0]       csr_wdata,
   input  logic [ant_pkg::CMD_W-1:0]       req_command,
   input  logic [ant_pkg::ADDR_W-1:0]      req_node_address,
   input  logic [ant_pkg::RSSI_W-1:0]      req_signal_strength,
   input  logic [ant_pkg::BATT_W-1:0]      req_battery_level,
   input  logic [ant_pkg::TEMP_W-1:0]      req_temperature_word,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [ant_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ant_pkg::SLOT_W-1:0]      rsp_slot_index,
   output logic [ant_pkg::ADDR_W-1:0]      rsp_out_address,
   output logic [ant_pkg::RSSI_W-1:0]      rsp_out_strength,
   output logic [ant_pkg::BATT_W-1:0]      rsp_out_battery,
   output logic [ant_pkg::TEMP_W-1:0]      rsp_out_temperature
);
   import ant_pkg::*;

   localparam int unsigned IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CW    = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned REC_W = $bits(ant_rec_type);

   // captured request
   logic [CMD_W-1:0]  cmd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [RSSI_W-1:0] rssi_ff;
   logic [BATT_W-1:0] batt_ff;
   logic [TEMP_W-1:0] temp_ff;

   logic [AGE_W-1:0]         max_age_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   // scan: read slot rd_cnt, evaluate slot eval_idx in the next cycle
   logic [CW-1:0] rd_cnt_ff, rd_cnt_in;
   logic          eval_vld_ff, eval_vld_in;
   logic [IW-1:0] eval_idx_ff, eval_idx_in;
   logic          free_found_ff, free_found_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;

   // pending result
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   ant_rec_type         res_rec_ff, res_rec_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   ant_rec_type         rsp_rec_ff;

   logic              ram_we, ram_re;
   logic [IW-1:0]     ram_waddr, ram_raddr;
   ant_rec_type       ram_wrec, rd_rec;
   logic [REC_W-1:0]  ram_rdata;

   logic              eval_on, slot_valid, addr_match, hit;
   logic [AGE_W:0]    age_next;
   logic              expire;

   ant_ram #(
      .WIDTH (REC_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_rec_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (REC_W'(ram_wrec)),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_rec     = ant_rec_type'(ram_rdata);
   assign eval_on    = ctl.scan && eval_vld_ff;
   assign slot_valid = valid_ff[eval_idx_ff];
   assign addr_match = (rd_rec.addr == addr_ff);
   assign age_next   = {1'b0, rd_rec.age} + {{AGE_W{1'b0}}, 1'b1};
   assign expire     = (age_next > {1'b0, max_age_ff});
   assign hit        = eval_on && slot_valid &&
                       (((cmd_ff == CMD_REPORT) && addr_match) ||
                        ((cmd_ff == CMD_TAKE) && !rd_rec.sent));

   assign ram_re    = ctl.scan && (rd_cnt_ff < CW'(TABLE_ENTRIES));
   assign ram_raddr = rd_cnt_ff[IW-1:0];

   always_comb begin
      rd_cnt_in     = rd_cnt_ff;
      eval_vld_in   = ram_re;
      eval_idx_in   = ram_raddr;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (ctl.start) begin
         rd_cnt_in     = '0;
         eval_vld_in   = 1'b0;
         free_found_in = 1'b0;
      end else if (ram_re) begin
         rd_cnt_in = rd_cnt_ff + CW'(1);
      end
      if (eval_on && !slot_valid && !free_found_ff && (cmd_ff == CMD_REPORT)) begin
         free_found_in = 1'b1;
         free_idx_in   = eval_idx_ff;
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = eval_idx_ff;
      ram_wrec  = rd_rec;
      valid_in  = valid_ff;
      if (eval_on && slot_valid) begin
         case (cmd_ff)
            CMD_REPORT: begin
               if (addr_match) begin
                  ram_we        = 1'b1;
                  ram_wrec.rssi = rssi_ff;
                  ram_wrec.batt = batt_ff;
                  ram_wrec.temp = temp_ff;
               end
            end
            CMD_TICK: begin
               if (expire) begin
                  valid_in[eval_idx_ff] = 1'b0;
               end else begin
                  ram_we       = 1'b1;
                  ram_wrec.age = age_next[AGE_W-1:0];
               end
            end
            CMD_TAKE: begin
               if (!rd_rec.sent) begin
                  ram_we        = 1'b1;
                  ram_wrec.sent = 1'b1;
               end
            end
            default: begin
               ram_we = 1'b0;
            end
         endcase
      end
      if (ctl.finish && (cmd_ff == CMD_REPORT) && free_found_ff) begin
         ram_we                = 1'b1;
         ram_waddr             = free_idx_ff;
         ram_wrec.addr         = addr_ff;
         ram_wrec.age          = '0;
         ram_wrec.sent         = 1'b0;
         ram_wrec.rssi         = rssi_ff;
         ram_wrec.batt         = batt_ff;
         ram_wrec.temp         = temp_ff;
         valid_in[free_idx_ff] = 1'b1;
      end
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_rec_in    = res_rec_ff;
      if (hit) begin
         res_slot_in = SLOT_W'(eval_idx_ff);
         res_rec_in  = '0;
         if (cmd_ff == CMD_TAKE) begin
            res_status_in = ST_TAKEN;
            res_rec_in    = rd_rec;
         end else begin
            res_status_in = ST_UPDATED;
         end
      end else if (ctl.finish) begin
         res_slot_in = '0;
         res_rec_in  = '0;
         case (cmd_ff)
            CMD_REPORT: begin
               if (free_found_ff) begin
                  res_status_in = ST_NEW;
                  res_slot_in   = SLOT_W'(free_idx_ff);
               end else begin
                  res_status_in = ST_FULL;
               end
            end
            CMD_TICK: res_status_in = ST_TICK;
            default:  res_status_in = ST_NONE;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff    <= MAX_AGE_RESET;
         valid_ff      <= '0;
         eval_vld_ff   <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            max_age_ff <= csr_wdata;
         end
         valid_ff      <= valid_in;
         eval_vld_ff   <= eval_vld_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         cmd_ff  <= req_command;
         addr_ff <= req_node_address;
         rssi_ff <= req_signal_strength;
         batt_ff <= req_battery_level;
         temp_ff <= req_temperature_word;
      end
      rd_cnt_ff     <= rd_cnt_in;
      eval_idx_ff   <= eval_idx_in;
      free_idx_ff   <= free_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_rec_ff    <= res_rec_in;
      if (ctl.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_rec_ff    <= res_rec_ff;
      end
   end

   assign stat.scan_end = eval_on && (eval_idx_ff == IW'(TABLE_ENTRIES - 1));
   assign stat.hit      = hit;
   assign stat.rsp_full = rsp_valid_ff;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_index      = rsp_slot_ff;
   assign rsp_out_address     = rsp_rec_ff.addr;
   assign rsp_out_strength    = rsp_rec_ff.rssi;
   assign rsp_out_battery     = rsp_rec_ff.batt;
   assign rsp_out_temperature = rsp_rec_ff.temp;

   `ANT_ASSERT_NOW(a_ram_no_collide, ram_we && ram_re, ram_waddr != ram_raddr, "read and write hit one slot")
   `ANT_ASSERT_NEXT(a_new_sets_valid, ctl.finish && (cmd_ff == CMD_REPORT) && free_found_ff, $countones(valid_ff) == $countones($past(valid_ff)) + 1, "new entry not marked valid")
endmodule

[hdl/aging_neighbor_table.sv]
// Aging neighbor table.
// req_chan (valid/ready) carries one command item: report a node record,
// age the table by one tick, or take the next unsent record. rsp_chan
// returns exactly one result item per command, in order.
// csr_we/csr_wdata write max_age; write only while the block is idle.
// Each item walks the record RAM one slot per cycle through its single
// read port; a report or take that finds its slot early ends the walk
// there. One item is in work at a time; req_chan.ready is high only
// between items.
// The result sits in an output register; a stalled receiver holds it
// there, and the next item may still be accepted and worked on, waiting
// only for the register to be freed before its own result is loaded.
// Reset clears all valid bits at once, returns max_age to 60 and drops
// any pending result; req_chan.ready stays low while reset is high.
// Depends on ant_pkg, the channel interfaces, ant_ctrl, ant_dpath, ant_ram.
module aging_neighbor_table #(
   parameter int unsigned TABLE_ENTRIES = ant_pkg::ANT_TABLE_ENTRIES
) (
   input  logic                      clock,
   input  logic                      reset,
   ant_req_if.sink                   req_chan,
   ant_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [ant_pkg::AGE_W-1:0] csr_wdata
);
   import ant_pkg::*;

   ant_ctl_type  ctl;
   ant_stat_type stat;

   ant_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   ant_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .ctl                  (ctl),
      .stat                 (stat),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata),
      .req_command          (req_chan.command),
      .req_node_address     (req_chan.node_address),
      .req_signal_strength  (req_chan.signal_strength),
      .req_battery_level    (req_chan.battery_level),
      .req_temperature_word (req_chan.temperature_word),
      .rsp_ready            (rsp_chan.ready),
      .rsp_valid            (rsp_chan.valid),
      .rsp_status           (rsp_chan.status),
      .rsp_slot_index       (rsp_chan.slot_index),
      .rsp_out_address      (rsp_chan.out_address),
      .rsp_out_strength     (rsp_chan.out_strength),
      .rsp_out_battery      (rsp_chan.out_battery),
      .rsp_out_temperature  (rsp_chan.out_temperature)
   );
endmodule

[tb/aging_neighbor_table_tb.sv]
// Self-checking testbench for aging_neighbor_table: drives report, tick and take items,
// predicts every result from a table model of its own and checks each one in order.
// Depends on ant_pkg, ant_req_if and ant_rsp_if from the RTL.
module aging_neighbor_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ant_pkg::*;

   localparam int unsigned SLOTS      = ANT_TABLE_ENTRIES;
   localparam int unsigned POOL_SIZE  = 24;
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned PHASE_ITEMS = 140;
   // top encoding of the command field, ignored by the block
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [ADDR_W-1:0]   addr;
      logic [RSSI_W-1:0]   rssi;
      logic [BATT_W-1:0]   batt;
      logic [TEMP_W-1:0]   temp;
   } table_result_type;

   class neighbor_scoreboard;
      logic [AGE_W-1:0]  max_age;
      bit                entry_valid[SLOTS];
      logic [ADDR_W-1:0] entry_addr[SLOTS];
      logic [AGE_W-1:0]  entry_age[SLOTS];
      bit                entry_sent[SLOTS];
      logic [RSSI_W-1:0] entry_rssi[SLOTS];
      logic [BATT_W-1:0] entry_batt[SLOTS];
      logic [TEMP_W-1:0] entry_temp[SLOTS];
      table_result_type  pending_results[$];
      int                mismatches;

      function new();
         max_age = MAX_AGE_RESET;
         mismatches = 0;
         foreach (entry_valid[i]) entry_valid[i] = 1'b0;
      endfunction

      function table_result_type apply_command(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                               logic [RSSI_W-1:0] rssi, logic [BATT_W-1:0] batt,
                                               logic [TEMP_W-1:0] temp);
         table_result_type r;
         int free_slot;
         bit done;
         logic [AGE_W:0] next_age;
         r = '0;
         done = 1'b0;
         free_slot = -1;
         case (cmd)
            CMD_REPORT: begin
               for (int i = 0; i < SLOTS && !done; i++) begin
                  if (!entry_valid[i]) begin
                     if (free_slot < 0) free_slot = i;
                  end else if (entry_addr[i] == addr) begin
                     // age and sent flag stay as they are
                     entry_rssi[i] = rssi;
                     entry_batt[i] = batt;
                     entry_temp[i] = temp;
                     r.status = ST_UPDATED;
                     r.slot = SLOT_W'(i);
                     done = 1'b1;
                  end
               end
               if (!done) begin
                  if (free_slot < 0) begin
                     r.status = ST_FULL;
                  end else begin
                     entry_valid[free_slot] = 1'b1;
                     entry_addr[free_slot] = addr;
                     entry_age[free_slot] = '0;
                     entry_sent[free_slot] = 1'b0;
                     entry_rssi[free_slot] = rssi;
                     entry_batt[free_slot] = batt;
                     entry_temp[free_slot] = temp;
                     r.status = ST_NEW;
                     r.slot = SLOT_W'(free_slot);
                  end
               end
            end
            CMD_TICK: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (entry_valid[i]) begin
                     next_age = {1'b0, entry_age[i]} + 1'b1;
                     if (next_age > {1'b0, max_age}) entry_valid[i] = 1'b0;
                     else entry_age[i] = next_age[AGE_W-1:0];
                  end
               end
               r.status = ST_TICK;
            end
            CMD_TAKE: begin
               r.status = ST_NONE;
               for (int i = 0; i < SLOTS && !done; i++) begin
                  if (entry_valid[i] && !entry_sent[i]) begin
                     entry_sent[i] = 1'b1;
                     r.status = ST_TAKEN;
                     r.slot = SLOT_W'(i);
                     r.addr = entry_addr[i];
                     r.rssi = entry_rssi[i];
                     r.batt = entry_batt[i];
                     r.temp = entry_temp[i];
                     done = 1'b1;
                  end
               end
            end
            default: r.status = ST_NONE;
         endcase
         return r;
      endfunction

      function void note_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                              logic [RSSI_W-1:0] rssi, logic [BATT_W-1:0] batt,
                              logic [TEMP_W-1:0] temp);
         pending_results.push_back(apply_command(cmd, addr, rssi, batt, temp));
      endfunction

      function void report_mismatch(string what, table_result_type want,
                                    table_result_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t %s: expected st %0d slot %0d addr %h rssi %h batt %h temp %h",
                     $time, what, want.status, want.slot, want.addr, want.rssi, want.batt,
                     want.temp);
            $display("   got st %0d slot %0d addr %h rssi %h batt %h temp %h",
                     got.status, got.slot, got.addr, got.rssi, got.batt, got.temp);
         end
      endfunction

      function void check_result(table_result_type got);
         table_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing outstanding", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.addr !== want.addr || got.rssi !== want.rssi ||
                got.batt !== want.batt || got.temp !== want.temp)
               report_mismatch("result mismatch", want, got);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we;
   logic [AGE_W-1:0]  csr_wdata;
   logic [ADDR_W-1:0] addr_pool[POOL_SIZE];
   int                req_run_left = 0;
   bit                req_idling = 1'b0;
   int                rsp_run_left = 0;
   bit                rsp_idling = 1'b0;
   int unsigned       idle_cycles = 0;
   neighbor_scoreboard sb = new;

   ant_req_if req_bus ();
   ant_rsp_if rsp_bus ();

   aging_neighbor_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // runs of items with random gaps are mixed with runs at full rate
   function automatic int draw_gap(inout int run_left, inout bit idling);
      if (run_left == 0) begin
         run_left = $urandom_range(8, 60);
         idling = ($urandom_range(0, 2) != 0);
      end
      run_left--;
      return idling ? $urandom_range(0, 17) : 0;
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic send_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                            logic [RSSI_W-1:0] rssi, logic [BATT_W-1:0] batt,
                            logic [TEMP_W-1:0] temp);
      int gap;
      gap = draw_gap(req_run_left, req_idling);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.node_address <= addr;
      req_bus.signal_strength <= rssi;
      req_bus.battery_level <= batt;
      req_bus.temperature_word <= temp;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_item(cmd, addr, rssi, batt, temp);
   endtask

   task automatic random_item();
      int pick;
      logic [CMD_W-1:0] cmd;
      logic [ADDR_W-1:0] addr;
      pick = $urandom_range(0, 99);
      if (pick < 50) cmd = CMD_REPORT;
      else if (pick < 70) cmd = CMD_TICK;
      else if (pick < 95) cmd = CMD_TAKE;
      else cmd = CMD_UNUSED;
      // mostly a known set of nodes, so updates, drops and take-backs happen
      addr = ($urandom_range(0, 6) == 0) ? rand_addr() : addr_pool[$urandom_range(0, POOL_SIZE-1)];
      send_item(cmd, addr, 8'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic idle_requests();
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_max_age(logic [AGE_W-1:0] value);
      idle_requests();
      while (sb.pending_results.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.max_age = value;
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.command <= CMD_REPORT;
      req_bus.node_address <= '0;
      req_bus.signal_strength <= '0;
      req_bus.battery_level <= '0;
      req_bus.temperature_word <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = rand_addr();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, update keeps the sent flag, unused command, full table
      send_item(CMD_REPORT, addr_pool[0], '0, '0, '0);
      send_item(CMD_REPORT, addr_pool[1], '1, '1, '1);
      send_item(CMD_REPORT, addr_pool[0], 8'h5a, 16'ha5c3, 16'h3c5a);
      send_item(CMD_TAKE, '1, '1, '1, '1);
      send_item(CMD_TAKE, '0, '0, '0, '0);
      send_item(CMD_TAKE, rand_addr(), 8'($urandom), 16'($urandom), 16'($urandom));
      send_item(CMD_REPORT, addr_pool[0], 8'h81, 16'h8001, 16'h7ffe);
      send_item(CMD_TAKE, '0, '0, '0, '0);
      send_item(CMD_UNUSED, '1, '1, '1, '1);
      send_item(CMD_TICK, '1, '1, '1, '1);
      for (int i = 2; i < SLOTS; i++)
         send_item(CMD_REPORT, addr_pool[i], 8'($urandom), 16'($urandom), 16'($urandom));
      send_item(CMD_REPORT, addr_pool[SLOTS], 8'($urandom), 16'($urandom), 16'($urandom));
      send_item(CMD_REPORT, addr_pool[1], 8'($urandom), 16'($urandom), 16'($urandom));

      // zero max age: one tick frees every entry
      write_max_age('0);
      send_item(CMD_TICK, '0, '0, '0, '0);
      send_item(CMD_TAKE, '0, '0, '0, '0);
      repeat (PHASE_ITEMS) random_item();

      write_max_age(16'd65534);
      repeat (PHASE_ITEMS) random_item();
      write_max_age(16'd1);
      repeat (PHASE_ITEMS) random_item();
      write_max_age(16'd5);
      repeat (PHASE_ITEMS) random_item();
      write_max_age(16'd20);
      repeat (PHASE_ITEMS) random_item();
      write_max_age(AGE_W'($urandom_range(0, 30)));
      repeat (PHASE_ITEMS) random_item();
      write_max_age(MAX_AGE_RESET);
      repeat (PHASE_ITEMS) random_item();

      idle_requests();
      while (sb.pending_results.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (sb.mismatches == 0)
         $display("aging_neighbor_table_tb: clean");
      else
         $display("aging_neighbor_table_tb: errors");
      $finish;
   end

   initial begin : rsp_side
      int stall;
      table_result_type got;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap(rsp_run_left, rsp_idling);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.status = rsp_bus.status;
         got.slot = rsp_bus.slot_index;
         got.addr = rsp_bus.out_address;
         got.rssi = rsp_bus.out_strength;
         got.batt = rsp_bus.out_battery;
         got.temp = rsp_bus.out_temperature;
         sb.check_result(got);
      end
   end

   // any accepted item on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("aging_neighbor_table_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
